// File: sv/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants for the hysteresis thermostat controller
// Holds the configuration, state, item and result structures and the setpoint
// clamp used by the tick logic.
// ----------------------------------------------------------------------------
package htc_pkg;

    // Setpoint limits and reset value, tenths of a degree
    localparam int SETPOINT_MIN   = -550;
    localparam int SETPOINT_MAX   = 1250;
    localparam int SETPOINT_RESET = 255;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP   = 2'd0;
    localparam logic [1:0] CFG_HYST   = 2'd1;
    localparam logic [1:0] CFG_MARGIN = 2'd2;
    localparam logic [1:0] CFG_ALARM  = 2'd3;

    // Configuration reset values
    localparam logic [6:0] STEP_RESET   = 7'd5;
    localparam logic [7:0] HYST_RESET   = 8'd5;
    localparam logic [8:0] MARGIN_RESET = 9'd20;

    typedef struct packed {
        logic [6:0] step_tenths;
        logic [7:0] hysteresis_tenths;
        logic [8:0] alarm_margin_tenths;
        logic       alarm_enable;
    } t_cfg;

    typedef struct packed {
        logic signed [11:0] setpoint;
        logic [2:0]         press_locks;    // bit 0 inc, bit 1 dec, bit 2 save
        logic               blink_phase;
        logic               heater_state;
        logic               alarm_state;
    } t_state;

    typedef struct packed {
        logic               inc_level;
        logic               dec_level;
        logic               save_level;
        logic signed [11:0] inside_temp;
    } t_item;

    typedef struct packed {
        logic               heater_on;
        logic               alarm_level;
        logic               save_strobe;
        logic signed [11:0] setpoint_now;
        logic               regulated;
    } t_result;

    // Saturate a 13-bit setpoint candidate to the sensor range
    function automatic logic signed [11:0] clamp_setpoint(input logic signed [12:0] v);
        logic signed [11:0] res;
        if (v < 13'(SETPOINT_MIN)) begin
            res = 12'(SETPOINT_MIN);
        end else if (v > 13'(SETPOINT_MAX)) begin
            res = 12'(SETPOINT_MAX);
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

endpackage

// File: sv/htc_tick.sv
// ----------------------------------------------------------------------------
// htc_tick: one thermostat tick
// Button edge detection, saturating setpoint update, alarm blink and heater
// hysteresis for one item, given the state left by the previous item.
// ----------------------------------------------------------------------------
module htc_tick
    import htc_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    logic               inc_fire;
    logic               dec_fire;
    logic               save_fire;
    logic               ran;
    logic signed [11:0] sp_inc;
    logic signed [11:0] sp_new;
    logic signed [12:0] sp_ext;
    logic signed [12:0] temp_ext;
    logic signed [12:0] alarm_limit;
    logic signed [12:0] heat_limit;
    logic               over_limit;
    logic               blink_nxt;
    logic               alarm_nxt;
    logic               heater_nxt;

    // Rising press: level high while the lock is clear
    assign inc_fire  = i_item.inc_level  & ~i_state.press_locks[0];
    assign dec_fire  = i_item.dec_level  & ~i_state.press_locks[1];
    assign save_fire = i_item.save_level & ~i_state.press_locks[2];

    // Regulation is skipped while inc or dec is held
    assign ran = ~(i_item.inc_level | i_item.dec_level);

    // Setpoint: increment first, then decrement, each saturating
    assign sp_inc = inc_fire
        ? clamp_setpoint(13'({i_state.setpoint[11], i_state.setpoint})
                         + $signed({6'd0, i_cfg.step_tenths}))
        : i_state.setpoint;
    assign sp_new = dec_fire
        ? clamp_setpoint(13'({sp_inc[11], sp_inc}) - $signed({6'd0, i_cfg.step_tenths}))
        : sp_inc;

    // Compare limits, 13 bits covers setpoint plus margin
    assign sp_ext      = {sp_new[11], sp_new};
    assign temp_ext    = {i_item.inside_temp[11], i_item.inside_temp};
    assign alarm_limit = sp_ext + $signed({4'd0, i_cfg.alarm_margin_tenths});
    assign heat_limit  = sp_ext - $signed({5'd0, i_cfg.hysteresis_tenths});
    assign over_limit  = temp_ext > alarm_limit;

    // Alarm blink and heater hysteresis
    always_comb begin
        blink_nxt  = i_state.blink_phase;
        alarm_nxt  = i_state.alarm_state;
        heater_nxt = i_state.heater_state;
        if (ran) begin
            if (i_cfg.alarm_enable) begin
                if (over_limit) begin
                    alarm_nxt = i_state.blink_phase;
                    blink_nxt = ~i_state.blink_phase;
                end else begin
                    alarm_nxt = 1'b0;
                    blink_nxt = 1'b0;
                end
            end
            if (temp_ext > sp_ext) begin
                heater_nxt = 1'b0;
            end
            if (temp_ext < heat_limit) begin
                heater_nxt = 1'b1;
            end
        end
    end

    // Locks follow the levels
    assign o_state.setpoint     = sp_new;
    assign o_state.press_locks  = {i_item.save_level, i_item.dec_level, i_item.inc_level};
    assign o_state.blink_phase  = blink_nxt;
    assign o_state.heater_state = heater_nxt;
    assign o_state.alarm_state  = alarm_nxt;

    assign o_result.heater_on    = heater_nxt;
    assign o_result.alarm_level  = i_cfg.alarm_enable & alarm_nxt;
    assign o_result.save_strobe  = save_fire;
    assign o_result.setpoint_now = sp_new;
    assign o_result.regulated    = ran;

endmodule

// File: sv/hysteresis_thermostat_controller.sv
// An accepted item passes the input register, the tick logic and the result
// register, whose contents are offered for transfer. Throughput: one item per
// cycle unless the result side stalls; the tick logic sits between the two
// registers and the thermostat state updates as each item enters the result register.
// Reset (synchronous, active low) restores the setpoint to 25.5 degrees, clears
// locks, heater, alarm and blink state, loads configuration defaults, empties both stages.
// ----------------------------------------------------------------------------
// hysteresis_thermostat_controller: bang-bang thermostat top level
// Two-stage valid/ready pipeline around the tick logic, with a plain
// configuration write port.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_controller
    import htc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_inc_level,
    input  logic               i_dec_level,
    input  logic               i_save_level,
    input  logic signed [11:0] i_inside_temp,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_heater_on,
    output logic               o_alarm_level,
    output logic               o_save_strobe,
    output logic signed [11:0] o_setpoint_now,
    output logic               o_regulated
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_result n_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;

    // Input stage moves on when the result register is free or being drained
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_tenths         <= STEP_RESET;
            r_cfg.hysteresis_tenths   <= HYST_RESET;
            r_cfg.alarm_margin_tenths <= MARGIN_RESET;
            r_cfg.alarm_enable        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP:   r_cfg.step_tenths         <= i_cfg_data[6:0];
                CFG_HYST:   r_cfg.hysteresis_tenths   <= i_cfg_data[7:0];
                CFG_MARGIN: r_cfg.alarm_margin_tenths <= i_cfg_data;
                CFG_ALARM:  r_cfg.alarm_enable        <= i_cfg_data[0];
                default:    r_cfg                     <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.inc_level   <= i_inc_level;
            r_item.dec_level   <= i_dec_level;
            r_item.save_level  <= i_save_level;
            r_item.inside_temp <= i_inside_temp;
        end
    end

    // Tick logic
    htc_tick u_tick (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Thermostat state, committed with each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.setpoint     <= 12'(SETPOINT_RESET);
            r_state.press_locks  <= 3'd0;
            r_state.blink_phase  <= 1'b0;
            r_state.heater_state <= 1'b0;
            r_state.alarm_state  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_heater_on    = r_result.heater_on;
    assign o_alarm_level  = r_result.alarm_level;
    assign o_save_strobe  = r_result.save_strobe;
    assign o_setpoint_now = r_result.setpoint_now;
    assign o_regulated    = r_result.regulated;

endmodule

// File: sv/htc_checker.sv
// ----------------------------------------------------------------------------
// htc_checker: port-level checks for the thermostat controller
// Watches the top-level ports only; attached by the bind at the end.
// ----------------------------------------------------------------------------
module htc_checker
    import htc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic               o_heater_on,
    input  logic               o_alarm_level,
    input  logic               o_save_strobe,
    input  logic signed [11:0] o_setpoint_now,
    input  logic               o_regulated
);

    // A stalled result holds its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_heater_on)
            && $stable(o_alarm_level) && $stable(o_save_strobe)
            && $stable(o_setpoint_now) && $stable(o_regulated))
        else $error("result changed while stalled");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // With the result register empty the input side must be open
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // Setpoint stays inside the sensor range
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_setpoint_now >= 12'(SETPOINT_MIN)
            && o_setpoint_now <= 12'(SETPOINT_MAX))
        else $error("setpoint out of range");

endmodule

bind hysteresis_thermostat_controller htc_checker u_htc_checker (.*);

// File: tb/sv/hysteresis_thermostat_controller_tb.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_controller_tb: self-checking bench for the thermostat
// A queue-fed driver offers button/temperature ticks in random bursts, and a
// monitor checks every result against an in-bench thermostat model. Several
// register settings are covered: defaults, range extremes, out-of-range
// writes and the alarm switched off and back on. One phase holds the result
// side off for a long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_controller_tb;
    import htc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 80;
    localparam int MAX_SHOWN    = 10;
    localparam int TEMP_LO      = -2048;
    localparam int TEMP_HI      = 2047;

    // Temperature patterns for generated ticks
    typedef enum logic [2:0] {
        T_HOT, T_COLD, T_BAND, T_EDGE, T_SPAN, T_RAW
    } t_temp_mode;

    // Result-side ready patterns
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_STEP;
    logic [8:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_inc_level = 1'b0;
    logic               i_dec_level = 1'b0;
    logic               i_save_level = 1'b0;
    logic signed [11:0] i_inside_temp = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_heater_on;
    logic               o_alarm_level;
    logic               o_save_strobe;
    logic signed [11:0] o_setpoint_now;
    logic               o_regulated;

    hysteresis_thermostat_controller dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_inc_level    (i_inc_level),
        .i_dec_level    (i_dec_level),
        .i_save_level   (i_save_level),
        .i_inside_temp  (i_inside_temp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_heater_on    (o_heater_on),
        .o_alarm_level  (o_alarm_level),
        .o_save_strobe  (o_save_strobe),
        .o_setpoint_now (o_setpoint_now),
        .o_regulated    (o_regulated)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Thermostat model: register copies and state
    logic [6:0] m_step     = STEP_RESET;
    logic [7:0] m_hyst     = HYST_RESET;
    logic [8:0] m_margin   = MARGIN_RESET;
    logic       m_alarm_en = 1'b0;
    int         m_setpoint = SETPOINT_RESET;
    logic [2:0] m_locks    = '0;    // last levels: bit 0 inc, bit 1 dec, bit 2 save
    logic       m_blink    = 1'b0;
    logic       m_heat     = 1'b0;
    logic       m_alarm    = 1'b0;

    // Stimulus and checking stores
    t_item      tick_q[$];          // ticks waiting to be offered
    t_result    due_q[$];           // results owed by the block, oldest first
    t_item      cur_tick;
    int         n_in = 0;
    int         n_out = 0;
    int         n_err = 0;
    int         n_strobe = 0;
    int         n_alarm_hi = 0;
    int         n_at_limit = 0;
    int         n_settings = 0;

    // Generator state: setpoint and levels as the generated ticks will leave them
    int         g_sp;
    logic [2:0] g_lv;
    int         g_run = 0;
    t_temp_mode g_mode = T_BAND;

    function automatic int limit_setpoint(input int v);
        if (v < SETPOINT_MIN) return SETPOINT_MIN;
        if (v > SETPOINT_MAX) return SETPOINT_MAX;
        return v;
    endfunction

    // Rising press on button b; a released level clears its lock
    function automatic logic button_press(input logic level, input int b);
        if (!level) begin
            m_locks[b] = 1'b0;
            return 1'b0;
        end
        if (m_locks[b]) return 1'b0;
        m_locks[b] = 1'b1;
        return 1'b1;
    endfunction

    // One thermostat tick: buttons first, then regulation unless inc/dec held
    function automatic t_result thermo_tick(input t_item it);
        t_result r;
        int      temp;
        logic    strobe;
        temp = {{20{it.inside_temp[11]}}, it.inside_temp};
        if (button_press(it.inc_level, 0))
            m_setpoint = limit_setpoint(m_setpoint + int'(m_step));
        if (button_press(it.dec_level, 1))
            m_setpoint = limit_setpoint(m_setpoint - int'(m_step));
        strobe = button_press(it.save_level, 2);
        r.regulated = (m_locks[1:0] == 2'b00);
        if (r.regulated) begin
            if (m_alarm_en) begin
                if (temp > m_setpoint + int'(m_margin)) begin
                    m_alarm = m_blink;
                    m_blink = ~m_blink;
                end else begin
                    m_blink = 1'b0;
                    m_alarm = 1'b0;
                end
            end
            if (temp > m_setpoint) m_heat = 1'b0;
            if (temp < m_setpoint - int'(m_hyst)) m_heat = 1'b1;
        end
        r.heater_on    = m_heat;
        r.alarm_level  = m_alarm_en ? m_alarm : 1'b0;
        r.save_strobe  = strobe;
        r.setpoint_now = m_setpoint[11:0];
        return r;
    endfunction

    // Random tick: buttons held for short runs, temperature in runs of one pattern
    function automatic t_item random_tick();
        t_item      it;
        logic [2:0] lv;
        int         t;
        lv = g_lv;
        for (int b = 0; b < 3; b++) begin
            if (lv[b]) lv[b] = ($urandom_range(0, 1) == 0);
            else       lv[b] = ($urandom_range(0, 9) == 0);
        end
        if ($urandom_range(0, 19) == 0) lv = 3'($urandom);
        if (lv[0] && !g_lv[0]) g_sp = limit_setpoint(g_sp + int'(m_step));
        if (lv[1] && !g_lv[1]) g_sp = limit_setpoint(g_sp - int'(m_step));
        g_lv = lv;

        if (g_run == 0) begin
            case ($urandom_range(0, 9))
                0, 1:    g_mode = T_HOT;
                2, 3:    g_mode = T_COLD;
                4, 5:    g_mode = T_BAND;
                6, 7:    g_mode = T_EDGE;
                8:       g_mode = T_SPAN;
                default: g_mode = T_RAW;
            endcase
            g_run = $urandom_range(1, 12);
        end
        g_run--;

        case (g_mode)
            T_HOT:  t = g_sp + int'(m_margin) + 1 + int'($urandom_range(0, 30));
            T_COLD: t = g_sp - int'(m_hyst) - 1 - int'($urandom_range(0, 30));
            T_BAND: t = g_sp - int'(m_hyst)
                        + int'($urandom_range(0, int'(m_hyst) + int'(m_margin)));
            T_EDGE: begin
                case ($urandom_range(0, 5))
                    0:       t = g_sp;
                    1:       t = g_sp + 1;
                    2:       t = g_sp - int'(m_hyst);
                    3:       t = g_sp - int'(m_hyst) - 1;
                    4:       t = g_sp + int'(m_margin);
                    default: t = g_sp + int'(m_margin) + 1;
                endcase
            end
            T_SPAN: t = int'($urandom_range(0, 1800)) + SETPOINT_MIN;
            default: t = int'($urandom_range(0, 4095)) + TEMP_LO;
        endcase
        if (t < TEMP_LO) t = TEMP_LO;
        if (t > TEMP_HI) t = TEMP_HI;
        it.inc_level   = lv[0];
        it.dec_level   = lv[1];
        it.save_level  = lv[2];
        it.inside_temp = t[11:0];
        return it;
    endfunction

    task automatic queue_tick(input logic inc, input logic dec, input logic sav,
                              input int temp);
        t_item it;
        it.inc_level   = inc;
        it.dec_level   = dec;
        it.save_level  = sav;
        it.inside_temp = temp[11:0];
        tick_q.push_back(it);
    endtask

    task automatic queue_random(input int n);
        g_sp  = m_setpoint;
        g_lv  = m_locks;
        g_run = 0;
        repeat (n) tick_q.push_back(random_tick());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_STEP:   m_step     = val[6:0];
            CFG_HYST:   m_hyst     = val[7:0];
            CFG_MARGIN: m_margin   = val[8:0];
            CFG_ALARM:  m_alarm_en = val[0];
            default:    ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [8:0] step, input logic [8:0] hyst,
                            input logic [8:0] margin, input logic [8:0] alarm);
        write_reg(CFG_STEP, step);
        write_reg(CFG_HYST, hyst);
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_ALARM, alarm);
        n_settings++;
    endtask

    // Wait until every tick is through and checked, then let the pipe settle;
    // sampled mid-cycle so the driver's updates for the edge have landed
    task automatic drain();
        @(negedge i_clk);
        while (tick_q.size() != 0 || i_in_valid || due_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Driver: bursts of transfers with random gaps; model runs on each transfer
    int   gap_left = 0;
    int   burst_left = 0;
    logic no_gaps = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                due_q.push_back(thermo_tick(cur_tick));
                n_in++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 && !no_gaps) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    cur_tick = tick_q.pop_front();
                    i_inc_level   <= cur_tick.inc_level;
                    i_dec_level   <= cur_tick.dec_level;
                    i_save_level  <= cur_tick.save_level;
                    i_inside_temp <= cur_tick.inside_temp;
                    i_in_valid    <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long result-side hold-off, started by a one-cycle kick
    int   stall_left = 0;
    logic stall_kick = 1'b0;

    always @(posedge i_clk) begin
        if (stall_kick) begin
            stall_left <= STALL_CYCLES;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Receiver: ready pattern changes at random between open, random and sparse
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    logic     rx_go;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(5, 40);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   rx_go = 1'b1;
            RX_RANDOM: rx_go = ($urandom_range(0, 1) == 0);
            default:   rx_go = ($urandom_range(0, 3) == 0);
        endcase
        i_out_ready <= rx_go && (stall_left == 0) && i_rst_n;
    end

    // Monitor: each result transfer against the oldest owed result
    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.heater_on    = o_heater_on;
            got.alarm_level  = o_alarm_level;
            got.save_strobe  = o_save_strobe;
            got.setpoint_now = o_setpoint_now;
            got.regulated    = o_regulated;
            n_out++;
            if (got.save_strobe) n_strobe++;
            if (got.alarm_level) n_alarm_hi++;
            if (got.setpoint_now == 12'(SETPOINT_MIN) || got.setpoint_now == 12'(SETPOINT_MAX))
                n_at_limit++;
            if (due_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_SHOWN)
                    $display("result %0d arrived with nothing owed", n_out);
            end else begin
                want = due_q.pop_front();
                if (got.heater_on !== want.heater_on || got.alarm_level !== want.alarm_level
                    || got.save_strobe !== want.save_strobe
                    || got.setpoint_now !== want.setpoint_now
                    || got.regulated !== want.regulated) begin
                    n_err++;
                    if (n_err <= MAX_SHOWN)
                        $display({"result %0d mismatch: heater %b/%b alarm %b/%b strobe %b/%b",
                                  " setpoint %0d/%0d regulated %b/%b (expected/actual)"},
                                 n_out, want.heater_on, got.heater_on, want.alarm_level,
                                 got.alarm_level, want.save_strobe, got.save_strobe,
                                 want.setpoint_now, got.setpoint_now, want.regulated,
                                 got.regulated);
                end
            end
        end
    end

    // Run limit
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, due_q.size());
            $display("hysteresis_thermostat_controller_tb: FAIL");
            $finish;
        end
    end

    // Phase sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: heater thresholds, button edges, holds and save
        n_settings++;
        queue_tick(0, 0, 0, SETPOINT_MIN);
        queue_tick(0, 0, 0, SETPOINT_MAX);
        queue_tick(0, 0, 0, TEMP_LO);
        queue_tick(0, 0, 0, TEMP_HI);
        queue_tick(0, 0, 0, 255);
        queue_tick(0, 0, 0, 250);
        queue_tick(0, 0, 0, 249);
        queue_tick(0, 0, 0, 256);
        queue_tick(1, 0, 0, 255);
        queue_tick(1, 0, 0, 100);
        queue_tick(0, 0, 0, 100);
        queue_tick(0, 1, 0, 300);
        queue_tick(0, 0, 0, 300);
        queue_tick(0, 0, 1, 255);
        queue_tick(0, 0, 1, 255);
        queue_tick(0, 0, 0, 255);
        queue_tick(1, 1, 1, 0);
        queue_tick(1, 1, 0, 0);
        queue_tick(0, 0, 0, -1);
        drain();

        // Largest step, zero band and margin: saturation both ways, alarm blink
        set_regs(9'd127, 9'd0, 9'd0, 9'd1);
        repeat (8) begin
            queue_tick(1, 0, 0, 0);
            queue_tick(0, 0, 0, 0);
        end
        queue_tick(0, 0, 0, TEMP_HI);
        queue_tick(0, 0, 0, TEMP_HI);
        queue_tick(0, 0, 0, TEMP_HI);
        queue_tick(0, 0, 0, SETPOINT_MAX + 1);
        queue_tick(0, 0, 0, SETPOINT_MAX);
        queue_tick(0, 0, 0, SETPOINT_MAX - 1);
        repeat (15) begin
            queue_tick(0, 1, 0, 0);
            queue_tick(0, 0, 0, 0);
        end
        queue_tick(0, 0, 0, SETPOINT_MIN - 1);
        queue_tick(0, 0, 0, SETPOINT_MIN);
        queue_tick(0, 0, 0, SETPOINT_MIN + 1);
        drain();

        // Random ticks under a range of settings
        set_regs(9'd1, 9'd0, 9'd0, 9'd1);
        queue_random(70);
        drain();

        set_regs(9'd100, 9'd200, 9'd500, 9'd1);
        queue_random(70);
        drain();

        // All-ones writes: masked to the widest value of each register
        set_regs(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
        queue_random(70);
        drain();

        // Alarm detached: pin stays low, alarm state frozen
        set_regs(9'd5, 9'd5, 9'd20, 9'd0);
        queue_random(50);
        drain();

        // Alarm back on with a zero step
        set_regs(9'd0, 9'd17, 9'd3, 9'd1);
        queue_random(50);
        drain();

        // Back-to-back offers while the result side holds off
        set_regs(9'($urandom_range(1, 100)), 9'($urandom_range(0, 200)),
                 9'($urandom_range(0, 500)), 9'($urandom_range(0, 1)));
        no_gaps <= 1'b1;
        queue_random(150);
        stall_kick <= 1'b1;
        @(posedge i_clk);
        stall_kick <= 1'b0;
        drain();
        no_gaps <= 1'b0;

        set_regs(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
        queue_random(70);
        drain();

        $display("%0d ticks in, %0d results checked over %0d register settings",
                 n_in, n_out, n_settings);
        $display("%0d save strobes, %0d alarm-high ticks, %0d ticks at a setpoint limit",
                 n_strobe, n_alarm_hi, n_at_limit);
        if (n_err == 0 && due_q.size() == 0) begin
            $display("hysteresis_thermostat_controller_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results owed", n_err, due_q.size());
            $display("hysteresis_thermostat_controller_tb: FAIL");
        end
        $finish;
    end

endmodule
